// ----- sv/rpd_pkg.sv -----
package rpd_pkg;

  // Run marker detection and run count extraction.
  localparam logic [7:0] RUN_MARK_MASK  = 8'hC0;
  localparam logic [7:0] RUN_COUNT_MASK = 8'h3F;

  // Image dimension limits.
  localparam int unsigned DIM_WIDTH = 17;
  localparam logic [DIM_WIDTH-1:0] DIM_MIN = 17'd1;
  localparam logic [DIM_WIDTH-1:0] DIM_MAX = 17'd65536;

  // Pixel counts reach 2^32, so they need one bit above the index width.
  localparam int unsigned INDEX_WIDTH = 32;
  localparam int unsigned COUNT_WIDTH = 33;
  localparam int unsigned RUN_WIDTH   = 6;

  // Configuration register map.
  localparam int unsigned CFG_ADDR_WIDTH = 3;
  localparam logic REG_IMAGE_WIDTH  = 1'b0;
  localparam logic REG_IMAGE_HEIGHT = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_image;
  } in_item_t;

  typedef struct packed {
    logic [7:0]             pixel_value;
    logic [INDEX_WIDTH-1:0] pixel_index;
    logic                   run_last;
    logic                   image_last;
    logic                   overrun;
  } out_item_t;

  // Classified byte as it waits in the queue between front and back.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_image;
    logic       is_marker;
  } cmd_t;

endpackage

// ----- sv/rpd_cfg.sv -----
module rpd_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [rpd_pkg::CFG_ADDR_WIDTH-1:0]  cfg_paddr,
  input  logic [31:0]                         cfg_pwdata,
  output logic [31:0]                         cfg_prdata,
  output logic                                cfg_pready,
  output logic [rpd_pkg::COUNT_WIDTH-1:0]     pixel_total
);
  import rpd_pkg::*;

  logic [DIM_WIDTH-1:0]   width_r, width_nxt;
  logic [DIM_WIDTH-1:0]   height_r, height_nxt;
  logic [COUNT_WIDTH-1:0] total_r, total_nxt;
  logic                   wr_en;
  logic                   reg_sel;
  logic [DIM_WIDTH-1:0]   wdata;
  logic [2*DIM_WIDTH-1:0] product;

  function automatic logic [DIM_WIDTH-1:0] clamp_dim(input logic [DIM_WIDTH-1:0] v);
    logic [DIM_WIDTH-1:0] r;
    r = v;
    if (v == '0) begin
      r = DIM_MIN;
    end else if (v > DIM_MAX) begin
      r = DIM_MAX;
    end
    return r;
  endfunction

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign reg_sel    = cfg_paddr[2];
  assign wdata      = cfg_pwdata[DIM_WIDTH-1:0];

  // The pixel total is refreshed at the same edge as the register write, with
  // the new value on one side of the multiplier and the stored one on the other.
  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    product    = clamp_dim(width_r) * clamp_dim(height_r);
    if (wr_en) begin
      case (reg_sel)
        REG_IMAGE_WIDTH: begin
          width_nxt = wdata;
          product   = clamp_dim(wdata) * clamp_dim(height_r);
        end
        REG_IMAGE_HEIGHT: begin
          height_nxt = wdata;
          product    = clamp_dim(width_r) * clamp_dim(wdata);
        end
        default: begin
          product = clamp_dim(width_r) * clamp_dim(height_r);
        end
      endcase
    end
    total_nxt = wr_en ? product[COUNT_WIDTH-1:0] : total_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= DIM_MIN;
      height_r <= DIM_MIN;
      total_r  <= COUNT_WIDTH'(1);
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
      total_r  <= total_nxt;
    end
  end

  always_comb begin
    case (reg_sel)
      REG_IMAGE_WIDTH:  cfg_prdata = {{(32-DIM_WIDTH){1'b0}}, width_r};
      REG_IMAGE_HEIGHT: cfg_prdata = {{(32-DIM_WIDTH){1'b0}}, height_r};
      default:          cfg_prdata = '0;
    endcase
  end

  assign pixel_total = total_r;

endmodule

// ----- sv/rpd_front.sv -----
module rpd_front #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  rpd_pkg::in_item_t in_data,
  output logic              cmd_valid,
  input  logic              cmd_pop,
  output rpd_pkg::cmd_t     cmd
);
  import rpd_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  cmd_t             q_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push;
  logic             pop;
  cmd_t             new_cmd;

  assign in_stall  = (count_r == CNT_FULL);
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (count_r != '0);
  assign pop       = cmd_pop && cmd_valid;
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    new_cmd.data_byte   = in_data.data_byte;
    new_cmd.start_image = in_data.start_image;
    new_cmd.is_marker   = ((in_data.data_byte & RUN_MARK_MASK) == RUN_MARK_MASK);
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= new_cmd;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("queue holds more entries than its depth");

  a_full_no_push: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == CNT_FULL && !pop) |=> count_r == CNT_FULL)
    else $error("queue lost an entry while full");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |=> (count_r <= CNT_W'(1)))
    else $error("queue grew by more than one from empty");

endmodule

// ----- sv/rpd_back.sv -----
module rpd_back (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cmd_valid,
  input  rpd_pkg::cmd_t                   cmd,
  output logic                            cmd_pop,
  input  logic [rpd_pkg::COUNT_WIDTH-1:0] pixel_total,
  output logic                            out_valid,
  input  logic                            out_stall,
  output rpd_pkg::out_item_t              out_data
);
  import rpd_pkg::*;

  // Decoder state.
  logic [COUNT_WIDTH-1:0] pixels_done_r, pixels_done_nxt;
  logic [RUN_WIDTH-1:0]   pending_r, pending_nxt;
  logic                   awaiting_r, awaiting_nxt;
  logic                   complete_r, complete_nxt;
  // Run in progress.
  logic [RUN_WIDTH-1:0]   rem_r, rem_nxt;
  logic [7:0]             value_r, value_nxt;
  logic                   clipped_r, clipped_nxt;
  // Output register.
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_r, out_nxt;

  logic                   out_free;
  logic                   running;
  logic                   pop;
  logic [COUNT_WIDTH-1:0] done_eff;
  logic [RUN_WIDTH-1:0]   pend_eff;
  logic                   await_eff;
  logic                   comp_eff;
  logic                   at_end;
  logic [COUNT_WIDTH-1:0] room;
  logic                   take_run;
  logic [RUN_WIDTH-1:0]   cnt_req;
  logic                   clip;
  logic [RUN_WIDTH-1:0]   cnt;
  logic                   emit;
  logic [COUNT_WIDTH-1:0] cur_done;
  logic [COUNT_WIDTH-1:0] next_done;
  logic [7:0]             e_value;
  logic [RUN_WIDTH-1:0]   left;
  logic                   e_clip;
  logic                   image_last;

  assign out_free = !out_valid_r || !out_stall;
  assign running  = (rem_r != '0);
  assign pop      = cmd_valid && !running && out_free;
  assign cmd_pop  = pop;

  // A start flag clears the image state before its own byte is looked at.
  assign done_eff  = cmd.start_image ? '0 : pixels_done_r;
  assign pend_eff  = cmd.start_image ? '0 : pending_r;
  assign await_eff = cmd.start_image ? 1'b0 : awaiting_r;
  assign comp_eff  = cmd.start_image ? 1'b0 : complete_r;

  assign at_end   = comp_eff || (done_eff >= pixel_total);
  assign room     = pixel_total - done_eff;
  assign take_run = pop && !at_end && (await_eff || !cmd.is_marker);
  assign cnt_req  = await_eff ? pend_eff : RUN_WIDTH'(1);
  assign clip     = ({{(COUNT_WIDTH-RUN_WIDTH){1'b0}}, cnt_req} > room);
  assign cnt      = clip ? room[RUN_WIDTH-1:0] : cnt_req;

  // The first pixel of a byte goes out in the cycle the byte is taken; the
  // remaining pixels of a run follow from the run registers.
  assign emit       = (take_run && cnt != '0) || (running && out_free);
  assign cur_done   = running ? pixels_done_r : done_eff;
  assign next_done  = cur_done + COUNT_WIDTH'(1);
  assign e_value    = running ? value_r : cmd.data_byte;
  assign left       = running ? rem_r - RUN_WIDTH'(1) : cnt - RUN_WIDTH'(1);
  assign e_clip     = running ? clipped_r : clip;
  assign image_last = (next_done == pixel_total);

  always_comb begin
    pixels_done_nxt = pixels_done_r;
    pending_nxt     = pending_r;
    awaiting_nxt    = awaiting_r;
    complete_nxt    = complete_r;
    rem_nxt         = rem_r;
    value_nxt       = value_r;
    clipped_nxt     = clipped_r;

    if (pop) begin
      pixels_done_nxt = done_eff;
      pending_nxt     = pend_eff;
      awaiting_nxt    = await_eff;
      complete_nxt    = comp_eff;
      if (at_end) begin
        complete_nxt = 1'b1;
      end else if (await_eff) begin
        awaiting_nxt = 1'b0;
      end else if (cmd.is_marker) begin
        pending_nxt  = cmd.data_byte[RUN_WIDTH-1:0] & RUN_COUNT_MASK[RUN_WIDTH-1:0];
        awaiting_nxt = 1'b1;
      end
    end

    if (emit) begin
      pixels_done_nxt = next_done;
      rem_nxt         = left;
      value_nxt       = e_value;
      clipped_nxt     = e_clip;
      if (image_last) begin
        complete_nxt = 1'b1;
      end
    end
  end

  always_comb begin
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (emit) begin
      out_valid_nxt       = 1'b1;
      out_nxt.pixel_value = e_value;
      out_nxt.pixel_index = cur_done[INDEX_WIDTH-1:0];
      out_nxt.run_last    = (left == '0);
      out_nxt.image_last  = image_last;
      out_nxt.overrun     = e_clip;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixels_done_r <= '0;
      pending_r     <= '0;
      awaiting_r    <= 1'b0;
      complete_r    <= 1'b0;
      rem_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      pixels_done_r <= pixels_done_nxt;
      pending_r     <= pending_nxt;
      awaiting_r    <= awaiting_nxt;
      complete_r    <= complete_nxt;
      rem_r         <= rem_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r   <= value_nxt;
    clipped_r <= clipped_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_last_completes: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && image_last) |=> complete_r)
    else $error("final pixel sent but image not marked complete");

  a_index_steps: assert property (@(posedge clk) disable iff (!rst_n)
    emit |=> pixels_done_r == $past(next_done))
    else $error("pixel count did not advance by one per pixel");

  a_no_pop_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    running |-> !cmd_pop)
    else $error("new byte taken while a run is still draining");

  a_run_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && left != '0) |=> running)
    else $error("run ended before its last pixel");

endmodule

// ----- sv/pcx_rle_pixel_decoder.sv -----
// Run-length decoder for the pixel data of a single-plane 8-bit PCX image.
//
// Input channel (in_valid / in_stall / in_data): one compressed byte per
// transaction. A byte with both top bits set is a run marker whose low six
// bits give a repeat count for the byte that follows; any other byte is one
// literal pixel. Setting start_image begins a new image with that byte.
// Output channel (out_valid / out_stall / out_data): one decoded pixel per
// transaction, with its row-major index and run, image-end and overrun flags.
// Bytes after the last pixel of the image produce nothing until a new start.
// Configuration: APB-style port with image_width at 0x0 and image_height at
// 0x4. Write them only while the block is idle.
//
// An accepted byte passes through the input queue to the pixel output
// register. A literal gives one pixel, a marker none, and a run value one
// pixel per cycle (up to 63) while the receiver does not stall, all through
// the single pixel output register. A two-entry queue keeps taking bytes
// while a run drains. When the receiver stalls, the output holds its pixel,
// the run pauses and, once the queue fills, in_stall rises. Reset empties the
// queue, drops any pending pixel and sets both dimensions to one.
module pcx_rle_pixel_decoder #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  rpd_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output rpd_pkg::out_item_t                  out_data,
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [rpd_pkg::CFG_ADDR_WIDTH-1:0]  cfg_paddr,
  input  logic [31:0]                         cfg_pwdata,
  output logic [31:0]                         cfg_prdata,
  output logic                                cfg_pready
);
  import rpd_pkg::*;

  logic                   cmd_valid;
  logic                   cmd_pop;
  cmd_t                   cmd;
  logic [COUNT_WIDTH-1:0] pixel_total;

  // Register file; also keeps the clamped width times height ready.
  rpd_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .pixel_total (pixel_total)
  );

  // Front: accepts bytes, tags run markers and queues them.
  rpd_front #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .cmd       (cmd)
  );

  // Back: tracks image state and expands runs into pixels.
  rpd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_valid   (cmd_valid),
    .cmd         (cmd),
    .cmd_pop     (cmd_pop),
    .pixel_total (pixel_total),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

// ----- test/pcx_rle_pixel_decoder_tb.sv -----
module pcx_rle_pixel_decoder_tb;
  import rpd_pkg::*;

  // The limit leaves ample room for every run value draining 63 pixels
  // under heavy random stalls.
  localparam int unsigned CYCLE_LIMIT = 600000;
  // Cycles to wait once nothing is expected, so that a marker byte still in
  // the block's input queue has settled before registers are touched.
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned RANDOM_TARGET = 405;
  localparam int unsigned MAX_PRINTED = 30;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_stall;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_item_t out_data;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [CFG_ADDR_WIDTH-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  pcx_rle_pixel_decoder dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_psel(cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr),
    .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Compressed bytes waiting to be driven, and the pixels the decoder model
  // says must come out, oldest first.
  in_item_t pending_bytes[$];
  out_item_t expected_pixels[$];

  int unsigned err_count = 0;
  int unsigned cycle_count = 0;
  int unsigned random_items = 0;
  // While set, neither side idles, giving a stretch at full rate.
  bit full_rate = 1'b0;

  // Decoder model state: its own copy of the dimension registers and of the
  // run-length state of the image being decoded.
  logic [DIM_WIDTH-1:0] img_w_reg = DIM_MIN;
  logic [DIM_WIDTH-1:0] img_h_reg = DIM_MIN;
  logic [COUNT_WIDTH-1:0] px_done = '0;
  logic [RUN_WIDTH-1:0] run_len = '0;
  bit want_value = 1'b0;
  bit img_done = 1'b0;

  // A dimension of zero behaves as one and anything past 65536 as 65536.
  function automatic logic [DIM_WIDTH-1:0] eff_dim(input logic [DIM_WIDTH-1:0] v);
    if (v < DIM_MIN) return DIM_MIN;
    if (v > DIM_MAX) return DIM_MAX;
    return v;
  endfunction

  function automatic logic [COUNT_WIDTH-1:0] image_total();
    logic [COUNT_WIDTH-1:0] w;
    logic [COUNT_WIDTH-1:0] h;
    w = COUNT_WIDTH'(eff_dim(img_w_reg));
    h = COUNT_WIDTH'(eff_dim(img_h_reg));
    return w * h;
  endfunction

  // Decodes one accepted byte and queues the pixels it must produce.
  function void decode_byte(input in_item_t item);
    logic [COUNT_WIDTH-1:0] total;
    logic [COUNT_WIDTH-1:0] room;
    logic [7:0] value;
    int unsigned cnt;
    bit clipped;
    out_item_t px;
    total = image_total();
    clipped = 1'b0;
    if (item.start_image) begin
      px_done = '0;
      run_len = '0;
      want_value = 1'b0;
      img_done = 1'b0;
    end
    // Past the end of the image (including after a shrink of the registers)
    // bytes are dropped and the image is marked complete.
    if (img_done || px_done >= total) begin
      img_done = 1'b1;
      return;
    end
    if (want_value) begin
      want_value = 1'b0;
      cnt = run_len;
      value = item.data_byte;
    end else if ((item.data_byte & RUN_MARK_MASK) == RUN_MARK_MASK) begin
      run_len = RUN_WIDTH'(item.data_byte & RUN_COUNT_MASK);
      want_value = 1'b1;
      return;
    end else begin
      cnt = 1;
      value = item.data_byte;
    end
    room = total - px_done;
    if (COUNT_WIDTH'(cnt) > room) begin
      cnt = 32'(room);
      clipped = 1'b1;
    end
    for (int unsigned k = 0; k < cnt; k++) begin
      px.pixel_value = value;
      px.pixel_index = px_done[INDEX_WIDTH-1:0];
      px.run_last = (k + 1 == cnt);
      px.image_last = (px_done + 1'b1 == total);
      px.overrun = clipped;
      expected_pixels.push_back(px);
      px_done = px_done + 1'b1;
    end
    if (px_done >= total) img_done = 1'b1;
  endfunction

  // Driver. A transaction completes at an edge with valid high and in_stall
  // low; a new byte (or idle cycle) is chosen only then or while valid is low,
  // so a stalled byte never changes. in_valid gets exactly one assignment here.
  always @(posedge clk) begin
    logic next_valid;
    bit accepted;
    accepted = in_valid && !in_stall;
    next_valid = in_valid;
    if (!rst_n) begin
      next_valid = 1'b0;
    end else begin
      if (accepted) decode_byte(in_data);
      if (!in_valid || accepted) begin
        if (pending_bytes.size() != 0 && (full_rate || $urandom_range(99) >= 32)) begin
          next_valid = 1'b1;
          in_data <= pending_bytes.pop_front();
        end else begin
          next_valid = 1'b0;
        end
      end
    end
    in_valid <= next_valid;
  end

  // Monitor. Each pixel transaction is checked field by field against the
  // oldest expected pixel; the stall toward the block is chosen at random.
  always @(posedge clk) begin
    out_item_t exp_px;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        err_count++;
        if (err_count <= MAX_PRINTED)
          $display("%0t: unexpected pixel, expected none, actual %p", $time, out_data);
      end else begin
        exp_px = expected_pixels.pop_front();
        if (out_data.pixel_value !== exp_px.pixel_value ||
            out_data.pixel_index !== exp_px.pixel_index ||
            out_data.run_last !== exp_px.run_last ||
            out_data.image_last !== exp_px.image_last ||
            out_data.overrun !== exp_px.overrun) begin
          err_count++;
          if (err_count <= MAX_PRINTED)
            $display("%0t: pixel mismatch, expected %p, actual %p", $time, exp_px, out_data);
        end
      end
    end
    out_stall <= rst_n && !full_rate && ($urandom_range(99) < 32);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("pcx_rle_pixel_decoder_tb: done, errors");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic start);
    in_item_t item;
    item.data_byte = b;
    item.start_image = start;
    pending_bytes.push_back(item);
  endtask

  // Waits until every queued byte has gone in and every pixel has come out,
  // then lets the block settle. This is also the point where the sender
  // pauses with nothing outstanding.
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_bytes.size() != 0 || in_valid || expected_pixels.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // A setup phase and an access phase; the register takes the value at the
  // edge where psel and penable are both high.
  task automatic write_reg(input logic idx, input logic [31:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    if (idx == REG_IMAGE_WIDTH) img_w_reg = value[DIM_WIDTH-1:0];
    else img_h_reg = value[DIM_WIDTH-1:0];
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  // Queues one image of random literals and runs, sized to the current
  // registers. Most runs fit; a few overshoot and get clipped. An image can
  // be cut short by the byte budget, sometimes right after a run marker, so
  // the next image's start lands on a broken sequence.
  task automatic queue_image(input int unsigned max_bytes);
    logic [COUNT_WIDTH-1:0] left;
    int unsigned n;
    int unsigned pick;
    int unsigned cnt;
    int unsigned cap;
    bit first;
    left = image_total();
    n = 0;
    first = 1'b1;
    while (left != 0 && n < max_bytes) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        push_byte(8'($urandom_range(0, 191)), first);
        left = left - 1'b1;
        n++;
      end else begin
        cap = (left < 63) ? int'(left) : 63;
        cnt = (pick < 93) ? $urandom_range(0, cap) : $urandom_range(1, 63);
        push_byte(RUN_MARK_MASK | 8'(cnt), first);
        push_byte(8'($urandom_range(0, 255)), 1'b0);
        left = (COUNT_WIDTH'(cnt) >= left) ? '0 : left - COUNT_WIDTH'(cnt);
        n += 2;
      end
      first = 1'b0;
    end
    if (left != 0 && $urandom_range(1) == 0) begin
      push_byte(RUN_MARK_MASK | 8'($urandom_range(0, 63)), 1'b0);
      n++;
    end
    random_items += n;
    // Trailing garbage after a finished image must be dropped.
    if (left == 0 && $urandom_range(3) == 0) begin
      repeat ($urandom_range(1, 2)) push_byte(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  initial begin
    int unsigned pick;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset dimensions give a one-pixel image: a literal finishes it, the
    // next byte is dropped, and a restarted run of three is clipped to one.
    push_byte(8'h00, 1'b1);
    push_byte(8'h55, 1'b0);
    push_byte(8'hC3, 1'b1);
    push_byte(8'h9A, 1'b0);
    wait_idle();

    // A 4x3 image: literals just below the marker range, a zero-length run
    // whose value yields nothing, a marker byte used as a run value, and a
    // full 63 run that overshoots the remaining eight pixels.
    write_reg(REG_IMAGE_WIDTH, 32'd4);
    write_reg(REG_IMAGE_HEIGHT, 32'd3);
    push_byte(8'hBF, 1'b1);
    push_byte(8'h7F, 1'b0);
    push_byte(8'hC0, 1'b0);
    push_byte(8'h12, 1'b0);
    push_byte(8'hC2, 1'b0);
    push_byte(8'hC7, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hAA, 1'b0);
    push_byte(8'h01, 1'b0);
    wait_idle();

    // Out-of-range dimensions: a width of zero acts as one and the largest
    // register value acts as 65536.
    write_reg(REG_IMAGE_WIDTH, 32'd0);
    write_reg(REG_IMAGE_HEIGHT, 32'h0001_FFFF);
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h80, 1'b0);
    wait_idle();

    // The largest image, with junk in the unused upper bits of the write.
    write_reg(REG_IMAGE_WIDTH, 32'hFFFF_0000);
    write_reg(REG_IMAGE_HEIGHT, 32'd65536);
    push_byte(8'hFE, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h3C, 1'b0);
    wait_idle();

    // Shrinking the image below what has already been decoded completes it,
    // so the following byte is dropped until a new start.
    write_reg(REG_IMAGE_WIDTH, 32'd5);
    write_reg(REG_IMAGE_HEIGHT, 32'd5);
    push_byte(8'h11, 1'b1);
    push_byte(8'hC5, 1'b0);
    push_byte(8'h22, 1'b0);
    wait_idle();
    write_reg(REG_IMAGE_WIDTH, 32'd2);
    write_reg(REG_IMAGE_HEIGHT, 32'd2);
    push_byte(8'h33, 1'b0);
    push_byte(8'h44, 1'b1);
    wait_idle();

    // Random images. Each phase drains, picks new dimensions (mostly small,
    // now and then at the extremes) and queues a few images back to back.
    // The first stretch runs without any idling on either side.
    full_rate = 1'b1;
    while (random_items < RANDOM_TARGET) begin
      if (random_items >= 80) full_rate = 1'b0;
      wait_idle();
      pick = $urandom_range(9);
      if (pick == 0) begin
        write_reg(REG_IMAGE_WIDTH, $urandom_range(65536, 131071));
        write_reg(REG_IMAGE_HEIGHT, 32'd0);
      end else if (pick == 1) begin
        write_reg(REG_IMAGE_WIDTH, 32'd1);
        write_reg(REG_IMAGE_HEIGHT, 32'd1);
      end else begin
        write_reg(REG_IMAGE_WIDTH, $urandom_range(1, 8));
        write_reg(REG_IMAGE_HEIGHT, $urandom_range(1, 8));
      end
      repeat ($urandom_range(1, 3)) begin
        queue_image(($urandom_range(7) == 0) ? $urandom_range(1, 6) : 40);
      end
    end
    full_rate = 1'b0;

    wait_idle();
    if (err_count == 0) begin
      $display("pcx_rle_pixel_decoder_tb: done, clean");
    end else begin
      $display("pcx_rle_pixel_decoder_tb: done, errors");
    end
    $finish;
  end

endmodule
